FILE: design/ssd_pkg.sv
// Shared constants for the skeleton dissimilarity scorer.
// Field widths, register map and reset values; no dependencies.
package ssd_pkg;

    localparam int COORD_W   = 16;
    localparam int CONF_W    = 16;
    localparam int WEIGHT_W  = 16;
    localparam int LIMIT_W   = 24;
    localparam int SCORE_W   = 24;
    localparam int MAG_W     = 16;                  // |dx|, |dy|
    localparam int SQ_W      = 2 * MAG_W;           // one squared difference
    localparam int DSQ_W     = SQ_W + 1;            // dx^2 + dy^2
    localparam int MUL_A_W   = 16;                  // serial operand, scanned LSB first
    localparam int MUL_B_W   = 24;                  // parallel operand
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_A_W);
    localparam int QUO_W     = WEIGHT_W;            // quotient never exceeds the weight
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam int DEF_MAX_KEYPOINTS = 32;

    localparam logic [SCORE_W-1:0] SUM_MAX = {SCORE_W{1'b1}};

    // register indexes
    localparam logic [2:0] REG_CONF_THR  = 3'd0;
    localparam logic [2:0] REG_KP_LIMIT  = 3'd1;
    localparam logic [2:0] REG_KP_WEIGHT = 3'd2;
    localparam logic [2:0] REG_CT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_CT_WEIGHT = 3'd4;

    // reset values
    localparam logic [CONF_W-1:0]   RST_CONF_THR  = 16'd3277;
    localparam logic [LIMIT_W-1:0]  RST_KP_LIMIT  = 24'd230400;
    localparam logic [WEIGHT_W-1:0] RST_KP_WEIGHT = 16'd4096;
    localparam logic [LIMIT_W-1:0]  RST_CT_LIMIT  = 24'd921600;
    localparam logic [WEIGHT_W-1:0] RST_CT_WEIGHT = 16'd20480;

endpackage

FILE: design/skeleton_dissimilarity_score.sv
// Top level of the skeleton dissimilarity scorer: register file, sequencer, accumulator.
// Uses ssd_pkg, ssd_mul (two instances) and ssd_div.
//
//  channel | direction | signals                       | contents
//  s_*     | in        | tvalid tready tdata tlast     | keypoint pair, tlast = box centres
//  m_*     | out       | tvalid tready tdata tuser     | final score, tuser = saturated
//  apb     | in/out    | psel penable pwrite paddr ... | five config registers at 4*i
//
// A keypoint past MAX_KEYPOINTS is only accepted; one with a confidence at or below threshold
// is accepted and then accumulated.
// Any other item is accepted, squared by both serial squarers, passed through the serial weight
// multiply and the bit-serial divide, then accumulated.
// A centre transaction waits in the accumulate step while the previous score is not taken;
// input is accepted again as soon as the score sits in the output register.
// Reset is asynchronous, active low, and restores register defaults and clears the sum.
module skeleton_dissimilarity_score
    import ssd_pkg::*;
#(
    parameter int MAX_KEYPOINTS = DEF_MAX_KEYPOINTS
)
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata: first_x, first_y, first_conf, second_x, second_y, second_conf (16 bits each)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,
    input  logic         s_tlast,
    // m_tdata: score (24 bits)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,
    // m_tuser: saturated (1 bit)
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int KP_CNT_W = $clog2(MAX_KEYPOINTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    // configuration
    logic [CONF_W-1:0]   conf_thr_reg;
    logic [LIMIT_W-1:0]  kp_limit_reg;
    logic [WEIGHT_W-1:0] kp_weight_reg;
    logic [LIMIT_W-1:0]  ct_limit_reg;
    logic [WEIGHT_W-1:0] ct_weight_reg;
    logic                cfg_wr;
    logic [2:0]          cfg_idx;

    logic [2:0]          state_reg, state_next;
    logic [KP_CNT_W-1:0] kp_count_reg, kp_count_next;
    logic [SCORE_W-1:0]  sum_reg, sum_next;
    logic                ovf_reg, ovf_next;
    logic                center_reg, center_next;
    logic [QUO_W-1:0]    term_reg, term_next;
    logic                m_valid_reg, m_valid_next;
    logic [SCORE_W-1:0]  m_score_reg;
    logic                m_sat_reg;
    logic                out_load;

    // datapath
    logic signed [COORD_W-1:0] first_x, first_y, second_x, second_y;
    logic [CONF_W-1:0]   first_conf, second_conf;
    logic [COORD_W:0]    dx, dy, dx_neg, dy_neg;
    logic [MAG_W-1:0]    mag_x, mag_y;
    logic                accept;
    logic                conf_ok;
    logic                start_sq, start_wc, start_div;
    logic [MUL_A_W-1:0]  mul_x_a;
    logic [MUL_B_W-1:0]  mul_x_b;
    logic                mul_x_done, mul_y_done;
    logic [MUL_P_W-1:0]  mul_x_p, mul_y_p;
    logic                div_done;
    logic [QUO_W-1:0]    div_q;
    logic [DSQ_W-1:0]    dsq;
    logic [LIMIT_W-1:0]  lim_sel, lim_eff, clamped;
    logic [WEIGHT_W-1:0] weight_sel;
    logic [SCORE_W:0]    acc_sum;
    logic                acc_sat;

    assign first_x     = s_tdata[15:0];
    assign first_y     = s_tdata[31:16];
    assign first_conf  = s_tdata[47:32];
    assign second_x    = s_tdata[63:48];
    assign second_y    = s_tdata[79:64];
    assign second_conf = s_tdata[95:80];

    // ---------------- APB register file ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_thr_reg  <= RST_CONF_THR;
            kp_limit_reg  <= RST_KP_LIMIT;
            kp_weight_reg <= RST_KP_WEIGHT;
            ct_limit_reg  <= RST_CT_LIMIT;
            ct_weight_reg <= RST_CT_WEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CONF_THR:  conf_thr_reg  <= pwdata[CONF_W-1:0];
                REG_KP_LIMIT:  kp_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_KP_WEIGHT: kp_weight_reg <= pwdata[WEIGHT_W-1:0];
                REG_CT_LIMIT:  ct_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_CT_WEIGHT: ct_weight_reg <= pwdata[WEIGHT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_CONF_THR:  prdata = {16'd0, conf_thr_reg};
            REG_KP_LIMIT:  prdata = {8'd0, kp_limit_reg};
            REG_KP_WEIGHT: prdata = {16'd0, kp_weight_reg};
            REG_CT_LIMIT:  prdata = {8'd0, ct_limit_reg};
            REG_CT_WEIGHT: prdata = {16'd0, ct_weight_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- coordinate differences ----------------
    assign dx     = {first_x[COORD_W-1], first_x} - {second_x[COORD_W-1], second_x};
    assign dy     = {first_y[COORD_W-1], first_y} - {second_y[COORD_W-1], second_y};
    assign dx_neg = ~dx + 1'b1;
    assign dy_neg = ~dy + 1'b1;
    // |d| <= 65535, so the low bits of the negation are exact
    assign mag_x  = dx[COORD_W] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
    assign mag_y  = dy[COORD_W] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];

    assign accept  = s_tvalid && s_tready;
    assign conf_ok = (first_conf > conf_thr_reg) && (second_conf > conf_thr_reg);

    // ---------------- term datapath ----------------
    assign lim_sel    = center_reg ? ct_limit_reg : kp_limit_reg;
    assign lim_eff    = (lim_sel == '0) ? LIMIT_W'(1) : lim_sel;
    assign weight_sel = center_reg ? ct_weight_reg : kp_weight_reg;
    assign dsq        = {1'b0, mul_x_p[SQ_W-1:0]} + {1'b0, mul_y_p[SQ_W-1:0]};
    assign clamped    = (dsq < {{(DSQ_W-LIMIT_W){1'b0}}, lim_eff}) ? dsq[LIMIT_W-1:0] : lim_eff;

    assign mul_x_a = start_wc ? weight_sel : mag_x;
    assign mul_x_b = start_wc ? clamped : {{(MUL_B_W-MAG_W){1'b0}}, mag_x};

    ssd_mul u_mul_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_sq | start_wc),
        .a     (mul_x_a),
        .b     (mul_x_b),
        .done  (mul_x_done),
        .p     (mul_x_p)
    );

    ssd_mul u_mul_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_sq),
        .a     (mag_y),
        .b     ({{(MUL_B_W-MAG_W){1'b0}}, mag_y}),
        .done  (mul_y_done),
        .p     (mul_y_p)
    );

    ssd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (mul_x_p),
        .divisor  (lim_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    assign acc_sum = {1'b0, sum_reg} + {{(SCORE_W+1-QUO_W){1'b0}}, term_reg};
    assign acc_sat = acc_sum[SCORE_W];

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_ACC) && center_reg && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        kp_count_next = kp_count_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        center_next   = center_reg;
        term_next     = term_reg;
        start_sq      = 1'b0;
        start_wc      = 1'b0;
        start_div     = 1'b0;
        m_valid_next  = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (s_tlast)
                    begin
                        center_next = 1'b1;
                        start_sq    = 1'b1;
                        state_next  = ST_SQ;
                    end
                    else if (kp_count_reg != KP_CNT_W'(MAX_KEYPOINTS))
                    begin
                        center_next   = 1'b0;
                        kp_count_next = kp_count_reg + 1'b1;
                        if (conf_ok)
                        begin
                            start_sq   = 1'b1;
                            state_next = ST_SQ;
                        end
                        else
                        begin
                            term_next  = kp_weight_reg;
                            state_next = ST_ACC;
                        end
                    end
                end
            end
            ST_SQ:
            begin
                if (mul_x_done)
                begin
                    start_wc   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_x_done)
                begin
                    start_div  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    term_next  = div_q;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (!center_reg)
                begin
                    sum_next   = acc_sat ? SUM_MAX : acc_sum[SCORE_W-1:0];
                    ovf_next   = ovf_reg | acc_sat;
                    state_next = ST_IDLE;
                end
                else if (out_load)
                begin
                    m_valid_next  = 1'b1;
                    sum_next      = '0;
                    ovf_next      = 1'b0;
                    kp_count_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            kp_count_reg <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
            center_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kp_count_reg <= kp_count_next;
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
            center_reg   <= center_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
        if (out_load)
        begin
            m_score_reg <= acc_sat ? SUM_MAX : acc_sum[SCORE_W-1:0];
            m_sat_reg   <= ovf_reg | acc_sat;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_score_reg;
    assign m_tuser[0] = m_sat_reg;

`ifndef SYNTHESIS
    a_kp_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kp_count_reg <= KP_CNT_W'(MAX_KEYPOINTS))
        else $error("keypoint count past limit");

    a_ovf_implies_max: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (sum_reg == SUM_MAX))
        else $error("overflow flag set with sum below maximum");

    a_sat_score_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_sat_reg) |-> (m_score_reg == SUM_MAX))
        else $error("saturated score not at maximum");

    a_div_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_done) |=> (state_reg == ST_ACC))
        else $error("divide result not accumulated");

    a_squares_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> (mul_x_done == mul_y_done))
        else $error("squarers out of step");
`endif

endmodule

FILE: design/ssd_mul.sv
// Shift-add multiplier, one bit of operand a per cycle.
// Depends on ssd_pkg for operand widths.
module ssd_mul
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] p
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_B_W:0]     sum;

    // upper half collects partial products, lower half holds the bits of a still to scan
    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_A_W]}
               + (prod_reg[0] ? {1'b0, b_reg} : {(MUL_B_W+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == MUL_CNT_W'(MUL_A_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_A_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{MUL_B_W{1'b0}}, a};
            b_reg    <= b;
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[MUL_A_W-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = prod_reg;

endmodule

FILE: design/ssd_div.sv
// Restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits QUO_W bits. Depends on ssd_pkg.
module ssd_div
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_P_W-1:0] dividend,
    input  logic [LIMIT_W-1:0] divisor,
    output logic               done,
    output logic [QUO_W-1:0]   quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [LIMIT_W-1:0]   d_reg;
    logic [LIMIT_W-1:0]   rem_reg;
    logic [QUO_W-1:0]     q_reg;
    logic [LIMIT_W:0]     trial;
    logic [LIMIT_W:0]     diff;
    logic                 ge;

    assign trial = {rem_reg, q_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(QUO_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(QUO_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // dividend bits shift out of q_reg as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[MUL_P_W-1:QUO_W];
            q_reg   <= dividend[QUO_W-1:0];
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: tb/skeleton_dissimilarity_score_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for skeleton_dissimilarity_score: directed table, then random pairs.
// Scores are predicted in-bench from the keypoint/centre rules; depends on ssd_pkg and the RTL.
module skeleton_dissimilarity_score_tb;
    import ssd_pkg::*;

    localparam int MAX_KP        = DEF_MAX_KEYPOINTS;
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int PHASE_ITEMS   = 100;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [15:0] fx, fy, fc, sx, sy, sc;
        logic        centre;
    } pose_pair_t;

    typedef struct packed {
        logic [23:0] score;
        logic        sat;
    } score_result_t;

    typedef struct packed {
        logic [7:0]    count;
        pose_pair_t    item;
        logic          typed;
        score_result_t want;
    } stim_row_t;

    typedef struct packed {
        logic [15:0] thr;
        logic [23:0] kp_limit;
        logic [15:0] kp_weight;
        logic [23:0] ct_limit;
        logic [15:0] ct_weight;
    } cfg_set_t;

    // default registers apply to the whole table
    localparam stim_row_t DIRECTED [15] = '{
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{24'd4096, 1'b0}},
        // confidence equal to threshold counts as low
        '{8'd1, '{16'd0, 16'd0, 16'd3277, 16'd0, 16'd0, 16'hFFFF, 1'b0}, 1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd3277, 1'b0}, 1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{24'd8192, 1'b0}},
        '{8'd1, '{16'h7FFF, 16'h7FFF, 16'd3278, 16'h7FFF, 16'h7FFF, 16'd3278, 1'b0},
              1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'h8000, 16'h8000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd0, 1'b1},
              1'b1, '{24'd20480, 1'b0}},
        '{8'd1, '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0},
              1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{24'd4096, 1'b0}},
        '{8'd1, '{-16'sd120, 16'd0, 16'hFFFF, 16'd120, 16'd0, 16'hFFFF, 1'b0},
              1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd160, 16'hFFFF, 16'd0, -16'sd80, 16'hFFFF, 1'b0},
              1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd16, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b0, '{24'd0, 1'b0}},
        // keypoints past the per-pair maximum are dropped
        '{8'd34, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}, 1'b0, '{24'd0, 1'b0}},
        '{8'd1, '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}, 1'b1, '{24'd131072, 1'b0}}
    };

    localparam cfg_set_t PHASE_CFG [4] = '{
        '{16'd0, 24'd0, 16'hFFFF, 24'd0, 16'hFFFF},
        '{16'hFFFF, 24'hFFFFFF, 16'd0, 24'hFFFFFF, 16'd0},
        '{16'd3277, 24'd1, 16'd4096, 24'd1, 16'hFFFF},
        '{RST_CONF_THR, RST_KP_LIMIT, RST_KP_WEIGHT, RST_CT_LIMIT, RST_CT_WEIGHT}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;     // first_x, first_y, first_conf, second_x, second_y, second_conf
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;     // score
    logic [0:0]  m_tuser;     // saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of registers and pair state
    logic [15:0] conf_thr;
    logic [23:0] kp_limit;
    logic [15:0] kp_weight;
    logic [23:0] ct_limit;
    logic [15:0] ct_weight;
    logic [23:0] acc_sum;
    logic        acc_sat;
    int unsigned kp_in_pair;

    score_result_t pending_scores [$];
    score_result_t want_score;
    int unsigned   errors;
    int unsigned   cycle_count;
    logic          rx_fast;

    skeleton_dissimilarity_score dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned weighted_term(input longint unsigned d,
                                                      input logic [23:0] limit,
                                                      input logic [15:0] weight);
        longint unsigned l;
        longint unsigned c;
        l = (limit == 24'd0) ? 64'd1 : 64'(limit);
        c = (d < l) ? d : l;
        return (longint'(weight) * c) / l;
    endfunction

    // advances the pair state by one item; returns 1 when a score leaves
    function automatic logic advance_score(input pose_pair_t it, output score_result_t res);
        longint          dx;
        longint          dy;
        longint unsigned d;
        longint unsigned add;
        logic [24:0]     total;
        res = '0;
        dx  = longint'($signed(it.fx)) - longint'($signed(it.sx));
        dy  = longint'($signed(it.fy)) - longint'($signed(it.sy));
        d   = dx * dx + dy * dy;
        if (it.centre)
            add = weighted_term(d, ct_limit, ct_weight);
        else if (kp_in_pair >= MAX_KP)
            return 1'b0;
        else
        begin
            kp_in_pair++;
            if (it.fc > conf_thr && it.sc > conf_thr)
                add = weighted_term(d, kp_limit, kp_weight);
            else
                add = 64'(kp_weight);
        end
        total = {1'b0, acc_sum} + 25'(add);
        if (total > {1'b0, SUM_MAX})
        begin
            total   = {1'b0, SUM_MAX};
            acc_sat = 1'b1;
        end
        acc_sum = total[23:0];
        if (!it.centre)
            return 1'b0;
        res.score  = acc_sum;
        res.sat    = acc_sat;
        acc_sum    = '0;
        acc_sat    = 1'b0;
        kp_in_pair = 0;
        return 1'b1;
    endfunction

    function automatic logic [15:0] pick_conf();
        case ($urandom_range(0, 5))
            0:       return conf_thr;
            1:       return conf_thr + 16'd1;
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(int'(conf_thr), 65535));
        endcase
    endfunction

    // mostly nearby points so the distance is often below the limit
    function automatic pose_pair_t random_pose_pair(input logic centre);
        pose_pair_t  it;
        int unsigned span;
        it.fx = 16'($urandom);
        it.fy = 16'($urandom);
        it.sx = 16'($urandom);
        it.sy = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            span  = 1 << $urandom_range(0, 12);
            it.sx = it.fx + 16'($urandom_range(0, 2 * span) - span);
            it.sy = it.fy + 16'($urandom_range(0, 2 * span) - span);
        end
        it.fc     = pick_conf();
        it.sc     = pick_conf();
        it.centre = centre;
        return it;
    endfunction

    task automatic drive_item(input pose_pair_t it, input int unsigned gap,
                              input logic typed, input score_result_t typed_want);
        score_result_t predicted;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.sc, it.sy, it.sx, it.fc, it.fy, it.fx};
        s_tlast  <= it.centre;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        if (advance_score(it, predicted))
            pending_scores = {pending_scores, (typed ? typed_want : predicted)};
    endtask

    // leaves psel high so back-to-back writes need one assignment per edge
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_CONF_THR:  conf_thr  = value[15:0];
            REG_KP_LIMIT:  kp_limit  = value[23:0];
            REG_KP_WEIGHT: kp_weight = value[15:0];
            REG_CT_LIMIT:  ct_limit  = value[23:0];
            REG_CT_WEIGHT: ct_weight = value[15:0];
            default: ;
        endcase
    endtask

    task automatic program_config(input cfg_set_t cfg);
        apb_write(REG_CONF_THR,  32'(cfg.thr));
        apb_write(REG_KP_LIMIT,  32'(cfg.kp_limit));
        apb_write(REG_KP_WEIGHT, 32'(cfg.kp_weight));
        apb_write(REG_CT_LIMIT,  32'(cfg.ct_limit));
        apb_write(REG_CT_WEIGHT, 32'(cfg.ct_weight));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending, drain every score, then give a dropped keypoint time to finish
    task automatic drain_scores();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected score transaction: score %0d saturated %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want_score = pending_scores.pop_front();
                if (m_tdata !== want_score.score)
                begin
                    $display("%0t: score expected %0d actual %0d",
                             $time, want_score.score, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want_score.sat)
                begin
                    $display("%0t: saturated expected %0d actual %0d",
                             $time, want_score.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // score receiver: random stall per transaction, with runs of no stall
    initial
    begin
        int unsigned stall;
        rx_fast = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_fast = !rx_fast;
            stall = rx_fast ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned pair_len;
        int unsigned k;
        int unsigned row;
        int unsigned rep;
        logic        fast;
        cfg_set_t    cfg;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        m_tready    <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        conf_thr    = RST_CONF_THR;
        kp_limit    = RST_KP_LIMIT;
        kp_weight   = RST_KP_WEIGHT;
        ct_limit    = RST_CT_LIMIT;
        ct_weight   = RST_CT_WEIGHT;
        acc_sum     = '0;
        acc_sat     = 1'b0;
        kp_in_pair  = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < $size(DIRECTED); row++)
            for (rep = 0; rep < DIRECTED[row].count; rep++)
                drive_item(DIRECTED[row].item, $urandom_range(0, 7),
                           DIRECTED[row].typed, DIRECTED[row].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase != 0)
            begin
                drain_scores();
                if (phase <= 3)
                    cfg = PHASE_CFG[phase - 1];
                else if (phase == NUM_PHASES - 1)
                    cfg = PHASE_CFG[3];
                else
                begin
                    cfg.thr       = 16'($urandom);
                    cfg.kp_limit  = $urandom_range(0, 1) ? 24'($urandom_range(1, 4096))
                                                         : 24'($urandom_range(1, 24'hFFFFFF));
                    cfg.kp_weight = 16'($urandom);
                    cfg.ct_limit  = $urandom_range(0, 1) ? 24'($urandom_range(1, 4096))
                                                         : 24'($urandom_range(1, 24'hFFFFFF));
                    cfg.ct_weight = 16'($urandom);
                end
                program_config(cfg);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                fast     = ($urandom_range(0, 3) == 0);
                // occasional long pairs that can run past the keypoint maximum
                pair_len = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_KP - 4, MAX_KP + 8)
                                                       : $urandom_range(0, 12);
                for (k = 0; k < pair_len; k++)
                    drive_item(random_pose_pair(1'b0), fast ? 0 : $urandom_range(0, 7),
                               1'b0, '0);
                drive_item(random_pose_pair(1'b1), fast ? 0 : $urandom_range(0, 7), 1'b0, '0);
                sent += pair_len + 1;
            end
        end

        drain_scores();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
